// File: sv/mtc_pkg.sv
// Shared types, constants and code tables of the Morse text codec.
`default_nettype none

package mtc_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned MAX_SYMBOLS = 4;

    localparam logic [7:0] CHR_DOT        = 8'h40;
    localparam logic [7:0] CHR_DASH       = 8'h23;
    localparam logic [7:0] CHR_SPACE      = 8'h20;
    localparam logic [7:0] CHR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHR_QUERY      = 8'h3F;
    localparam logic [7:0] CHR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CHR_TAB        = 8'h09;
    localparam logic [7:0] CHR_CR         = 8'h0D;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef enum logic [1:0] {
        CMD_ENC_LETTER,
        CMD_ENC_SPACE,
        CMD_DEC_CHAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [2:0] sym_len;
        logic [3:0] sym_bits;
        logic [7:0] chr;
    } t_cmd;

    function automatic logic [2:0] code_len(input logic [4:0] k);
        logic [2:0] len;
        unique case (k)
            5'd4, 5'd19:                                  len = 3'd1;
            5'd0, 5'd8, 5'd12, 5'd13:                     len = 3'd2;
            5'd3, 5'd6, 5'd10, 5'd14, 5'd17, 5'd18,
            5'd20, 5'd22:                                 len = 3'd3;
            default:                                      len = 3'd4;
        endcase
        return len;
    endfunction

    function automatic logic [3:0] code_bits(input logic [4:0] k);
        logic [3:0] bits;
        unique case (k)
            5'd0:  bits = 4'd1;   5'd1:  bits = 4'd8;   5'd2:  bits = 4'd10;
            5'd3:  bits = 4'd4;   5'd4:  bits = 4'd0;   5'd5:  bits = 4'd2;
            5'd6:  bits = 4'd6;   5'd7:  bits = 4'd0;   5'd8:  bits = 4'd0;
            5'd9:  bits = 4'd7;   5'd10: bits = 4'd5;   5'd11: bits = 4'd4;
            5'd12: bits = 4'd3;   5'd13: bits = 4'd2;   5'd14: bits = 4'd7;
            5'd15: bits = 4'd6;   5'd16: bits = 4'd13;  5'd17: bits = 4'd2;
            5'd18: bits = 4'd0;   5'd19: bits = 4'd1;   5'd20: bits = 4'd1;
            5'd21: bits = 4'd1;   5'd22: bits = 4'd3;   5'd23: bits = 4'd9;
            5'd24: bits = 4'd11;  5'd25: bits = 4'd12;
            default: bits = 4'd0;
        endcase
        return bits;
    endfunction

    // Letter for a symbol pattern, or a question mark when no letter matches.
    function automatic logic [7:0] decode_letter(input logic [2:0] len,
                                                 input logic [3:0] pat);
        logic [7:0] res;
        res = CHR_QUERY;
        for (int k = 25; k >= 0; k--) begin
            if (code_len(5'(k)) == len && code_bits(5'(k)) == pat) begin
                res = CHR_LOWER_A + 8'(k);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/mtc_front.sv
// Front end: accepts input beats, tracks the decode token and issues commands.
`default_nettype none

module mtc_front
    import mtc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    input  wire logic       i_cfg_direction_mode,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_text_last,
    output t_cmd            o_cmd,
    output logic            o_cmd_valid
);

    logic       r_mode;
    logic [2:0] r_tok_len;
    logic [3:0] r_tok_pat;
    logic       r_tok_inv;
    logic       r_tok_und;

    logic [2:0] n_tok_len;
    logic [3:0] n_tok_pat;
    logic       n_tok_inv;
    logic       n_tok_und;

    logic       is_ws;
    logic       is_sym;
    logic       is_dash;
    logic       is_letter;
    logic       tok_done;
    logic [4:0] letter_idx;
    logic [7:0] letter_off;
    logic [7:0] tok_char;

    always_comb begin
        is_ws     = (i_char_in == CHR_SPACE) ||
                    (i_char_in >= CHR_TAB && i_char_in <= CHR_CR);
        is_dash   = (i_char_in == CHR_DASH);
        is_sym    = is_dash || (i_char_in == CHR_DOT);
        is_letter = (i_char_in >= CHR_LOWER_A) && (i_char_in <= CHR_LOWER_Z);
        letter_off = i_char_in - CHR_LOWER_A;
        letter_idx = letter_off[4:0];
    end

    always_comb begin
        n_tok_len = r_tok_len;
        n_tok_pat = r_tok_pat;
        n_tok_inv = r_tok_inv;
        n_tok_und = r_tok_und;
        if (!is_ws) begin
            if (r_tok_len == 3'd0) begin
                n_tok_und = (i_char_in == CHR_UNDERSCORE);
                n_tok_inv = !(is_sym || n_tok_und);
                n_tok_pat = {3'b000, is_dash};
                n_tok_len = 3'd1;
            end else if (r_tok_und || !is_sym || r_tok_len >= 3'(MAX_SYMBOLS)) begin
                n_tok_inv = 1'b1;
            end else begin
                n_tok_pat = {r_tok_pat[2:0], is_dash};
                n_tok_len = r_tok_len + 3'd1;
            end
        end
        tok_done = (is_ws || i_text_last) && (n_tok_len != 3'd0);
        if (n_tok_inv) begin
            tok_char = CHR_QUERY;
        end else if (n_tok_und) begin
            tok_char = CHR_SPACE;
        end else begin
            tok_char = decode_letter(n_tok_len, n_tok_pat);
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd_valid    = 1'b0;
        o_cmd.sym_len  = code_len(letter_idx);
        o_cmd.sym_bits = code_bits(letter_idx);
        o_cmd.chr      = tok_char;
        if (r_mode == MODE_ENCODE) begin
            if (is_letter) begin
                o_cmd.kind  = CMD_ENC_LETTER;
                o_cmd_valid = i_accept;
            end else if (i_char_in == CHR_SPACE) begin
                o_cmd.kind  = CMD_ENC_SPACE;
                o_cmd_valid = i_accept;
            end
        end else begin
            o_cmd.kind  = CMD_DEC_CHAR;
            o_cmd_valid = i_accept && tok_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_ENCODE;
            r_tok_len <= 3'd0;
            r_tok_pat <= 4'd0;
            r_tok_inv <= 1'b0;
            r_tok_und <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mode    <= i_cfg_direction_mode;
            r_tok_len <= 3'd0;
            r_tok_pat <= 4'd0;
            r_tok_inv <= 1'b0;
            r_tok_und <= 1'b0;
        end else if (i_accept && r_mode == MODE_DECODE) begin
            if (tok_done) begin
                r_tok_len <= 3'd0;
                r_tok_pat <= 4'd0;
                r_tok_inv <= 1'b0;
                r_tok_und <= 1'b0;
            end else begin
                r_tok_len <= n_tok_len;
                r_tok_pat <= n_tok_pat;
                r_tok_inv <= n_tok_inv;
                r_tok_und <= n_tok_und;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/mtc_cmd_fifo.sv
// Short command queue between the front end and the byte emitter.
`default_nettype none

module mtc_cmd_fifo
    import mtc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr_en,
    input  wire t_cmd i_wr_data,
    output logic      o_full,
    input  wire logic i_rd_en,
    output t_cmd      o_rd_data,
    output logic      o_rd_valid
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign do_wr      = i_wr_en && !o_full;
    assign do_rd      = i_rd_en && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Command queue count exceeds its depth.");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("Command queue pointers differ while the queue is empty.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_wr && !do_rd) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("Command queue count did not follow a write.");

endmodule

`default_nettype wire

// File: sv/mtc_back.sv
// Back end: expands commands into output bytes and holds the output register.
`default_nettype none

module mtc_back
    import mtc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire logic       i_cmd_valid,
    output logic            o_cmd_take,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [7:0]      o_char_out,
    output logic            o_run_last
);

    t_cmd       r_cmd;
    logic       r_busy;
    logic [2:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;

    logic       out_free;
    logic       emit;
    logic [7:0] emit_char;
    logic       emit_last;
    logic [2:0] sym_pos;

    assign out_free   = !r_out_valid || i_pop;
    assign emit       = r_busy && out_free;
    assign o_cmd_take = i_cmd_valid && (!r_busy || (emit && emit_last));
    assign o_empty    = !r_out_valid;
    assign o_char_out = r_out_char;
    assign o_run_last = r_out_last;
    assign sym_pos    = r_cmd.sym_len - 3'd1 - r_idx;

    always_comb begin
        emit_char = CHR_SPACE;
        emit_last = 1'b1;
        unique case (r_cmd.kind)
            CMD_ENC_LETTER: begin
                if (r_idx < r_cmd.sym_len) begin
                    emit_char = r_cmd.sym_bits[sym_pos[1:0]] ? CHR_DASH : CHR_DOT;
                    emit_last = 1'b0;
                end
            end
            CMD_ENC_SPACE: begin
                emit_last = (r_idx == 3'd2);
                emit_char = (r_idx == 3'd1) ? CHR_UNDERSCORE : CHR_SPACE;
            end
            CMD_DEC_CHAR: begin
                emit_char = r_cmd.chr;
            end
            default: begin
                emit_char = CHR_QUERY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_out_char <= emit_char;
            r_out_last <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_take) begin
                r_busy <= 1'b1;
                r_idx  <= 3'd0;
            end else if (emit) begin
                r_busy <= !emit_last;
                r_idx  <= r_idx + 3'd1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_letter_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cmd.kind == CMD_ENC_LETTER) |-> (r_idx <= r_cmd.sym_len))
        else $error("Letter expansion ran past its symbol count.");

    a_space_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cmd.kind == CMD_ENC_SPACE) |-> (r_idx <= 3'd2))
        else $error("Space expansion ran past three bytes.");

    a_dec_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cmd.kind == CMD_DEC_CHAR) |-> (r_idx == 3'd0))
        else $error("Decoded character emitted more than one byte.");

endmodule

`default_nettype wire

// File: sv/morse_text_codec_top.sv
// Top level of the Morse text codec: front end, command queue and byte emitter.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+-------------------------------
//  input   | in        | push / full                | i_char_in[7:0], i_text_last
//  result  | out       | pop / empty                | o_char_out[7:0], o_run_last
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_direction_mode
//
// The front end takes one input beat per cycle while the command queue has room.
// The emitter produces one output byte per cycle while its output is free;
// a beat causes up to five bytes for an encoded letter, three for an encoded space,
// one or none in decode mode; the output byte rate sets the sustained beat rate.
// Reset is synchronous and active low; it clears the token, the queue and the mode.
// A stalled output only backs up the queue; the front keeps accepting until it fills.
`default_nettype none

module morse_text_codec_top
    import mtc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_direction_mode,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_text_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_char_out,
    output logic            o_run_last
);

    t_cmd front_cmd;
    logic front_cmd_valid;
    t_cmd queue_cmd;
    logic queue_valid;
    logic queue_take;
    logic in_accept;
    logic cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign in_accept   = push && !full;

    mtc_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (cfg_write),
        .i_cfg_direction_mode (i_cfg_direction_mode),
        .i_accept             (in_accept),
        .i_char_in            (i_char_in),
        .i_text_last          (i_text_last),
        .o_cmd                (front_cmd),
        .o_cmd_valid          (front_cmd_valid)
    );

    mtc_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (front_cmd_valid),
        .i_wr_data  (front_cmd),
        .o_full     (full),
        .i_rd_en    (queue_take),
        .o_rd_data  (queue_cmd),
        .o_rd_valid (queue_valid)
    );

    mtc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_valid (queue_valid),
        .o_cmd_take  (queue_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_char_out  (o_char_out),
        .o_run_last  (o_run_last)
    );

endmodule

`default_nettype wire
